>>> rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is low.
`define CHS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define CHS_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> rtl/chs_pkg.sv
`default_nettype none
package chs_pkg;

	localparam int unsigned BUCKETS = 1024;
	localparam int unsigned NODES   = 4096;
	localparam int unsigned KEY_W   = 31;

	// bucket index is the low key bits, so BUCKETS stays a power of two
	localparam int unsigned BKT_W = $clog2(BUCKETS);
	localparam int unsigned IDX_W = $clog2(NODES);
	localparam int unsigned CNT_W = $clog2(NODES + 1);

	localparam logic [CNT_W-1:0] NODES_C = CNT_W'(NODES);
	localparam logic [BKT_W-1:0] BKT_LAST = BKT_W'(BUCKETS - 1);

	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_SEARCH = 1'b1;

	typedef struct packed {
		logic             kind;
		logic [KEY_W-1:0] key;
	} chs_in_t;

	typedef struct packed {
		logic found;
		logic status;
	} chs_out_t;

	typedef struct packed {
		logic             used;
		logic [IDX_W-1:0] first;
		logic [IDX_W-1:0] tail;
	} chs_bkt_t;

	localparam int unsigned BKT_ENTRY_W = $bits(chs_bkt_t);

endpackage
`default_nettype wire

>>> rtl/chs_ram.sv
`default_nettype none
module chs_ram #(
	parameter int unsigned DEPTH = 2,
	parameter int unsigned WIDTH = 1,
	localparam int unsigned AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

>>> rtl/chained_hash_set_top.sv
`default_nettype none
// channel | direction | handshake            | payload
// req     | in        | req_valid, req_ready | chs_in_t  {kind, key}
// rsp     | out       | rsp_valid, rsp_ready | chs_out_t {found, status}
//
// Insert: bucket read, node/bucket write, result load.
// Search: bucket read, then one ST_WALK step per chain node visited in the node memory read loop, then result load.
// After reset, a clearing pass writes each of the BUCKETS entries (1024) to empty the bucket table;
// req_ready stays low until it ends.
// One item in flight; a new item is taken while the previous result waits in rsp.
// Result loading waits only if rsp still holds an untaken result.
module chained_hash_set_top
	import chs_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     req_valid,
	output logic          req_ready,
	input  wire chs_in_t  req,
	output logic          rsp_valid,
	input  wire logic     rsp_ready,
	output chs_out_t      rsp
);

	`include "assert_macros.svh"

	typedef enum logic [4:0] {
		ST_CLEAR = 5'b00001,
		ST_IDLE  = 5'b00010,
		ST_BKT   = 5'b00100,
		ST_WALK  = 5'b01000,
		ST_DONE  = 5'b10000
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] nodes_taken_q;
	logic [BKT_W-1:0] clr_q;
	logic             rsp_valid_q;

	logic             kind_q;
	logic [KEY_W-1:0] key_q;
	logic [IDX_W-1:0] cur_q;
	logic [IDX_W-1:0] tail_q;
	logic             res_found_q;
	logic             res_status_q;
	chs_out_t         rsp_q;

	logic                   bkt_we;
	logic [BKT_W-1:0]       bkt_waddr;
	chs_bkt_t               bkt_wdata;
	logic [BKT_ENTRY_W-1:0] bkt_rdata;
	chs_bkt_t               bkt_rd;

	logic             key_we;
	logic [KEY_W-1:0] key_rdata;
	logic             link_we;
	logic [IDX_W-1:0] link_waddr;
	logic [IDX_W-1:0] link_rdata;
	logic [IDX_W-1:0] node_raddr;
	logic [IDX_W-1:0] fresh;

	logic accept;
	logic pool_full;
	logic rsp_free;

	assign req_ready = (state_q == ST_IDLE);
	assign accept    = req_valid && req_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign rsp_free  = !rsp_valid_q || rsp_ready;

	assign fresh     = nodes_taken_q[IDX_W-1:0];
	assign pool_full = (nodes_taken_q == NODES_C);
	assign bkt_rd    = chs_bkt_t'(bkt_rdata);

	always_comb begin
		bkt_we     = 1'b0;
		bkt_waddr  = key_q[BKT_W-1:0];
		bkt_wdata  = '0;
		key_we     = 1'b0;
		link_we    = 1'b0;
		link_waddr = bkt_rd.tail;
		node_raddr = cur_q;
		case (state_q)
			ST_CLEAR: begin
				bkt_we    = 1'b1;
				bkt_waddr = clr_q;
			end
			ST_BKT: begin
				node_raddr = bkt_rd.first;
				if (kind_q == KIND_INSERT && !pool_full) begin
					bkt_we          = 1'b1;
					bkt_wdata.used  = 1'b1;
					bkt_wdata.first = bkt_rd.used ? bkt_rd.first : fresh;
					bkt_wdata.tail  = fresh;
					key_we          = 1'b1;
					// old tail gains the fresh node as successor
					link_we         = bkt_rd.used;
				end
			end
			ST_WALK: begin
				node_raddr = link_rdata;
			end
			default: begin
			end
		endcase
	end

	chs_ram #(.DEPTH(BUCKETS), .WIDTH(BKT_ENTRY_W)) u_bkt_ram (
		.clk   (clk),
		.we    (bkt_we),
		.waddr (bkt_waddr),
		.wdata (bkt_wdata),
		.raddr (req.key[BKT_W-1:0]),
		.rdata (bkt_rdata)
	);

	chs_ram #(.DEPTH(NODES), .WIDTH(KEY_W)) u_key_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (fresh),
		.wdata (key_q),
		.raddr (node_raddr),
		.rdata (key_rdata)
	);

	chs_ram #(.DEPTH(NODES), .WIDTH(IDX_W)) u_link_ram (
		.clk   (clk),
		.we    (link_we),
		.waddr (link_waddr),
		.wdata (fresh),
		.raddr (node_raddr),
		.rdata (link_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLEAR;
			nodes_taken_q <= '0;
			clr_q         <= '0;
			rsp_valid_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == BKT_LAST) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_BKT;
					end
				end
				ST_BKT: begin
					if (kind_q == KIND_INSERT) begin
						if (!pool_full) begin
							nodes_taken_q <= nodes_taken_q + 1'b1;
						end
						state_q <= ST_DONE;
					end else if (bkt_rd.used) begin
						state_q <= ST_WALK;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_WALK: begin
					if (key_rdata == key_q || cur_q == tail_q) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (rsp_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_CLEAR;
			endcase

			if (state_q == ST_DONE && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= req.kind;
			key_q  <= req.key;
		end
		case (state_q)
			ST_BKT: begin
				cur_q        <= bkt_rd.first;
				tail_q       <= bkt_rd.tail;
				res_found_q  <= 1'b0;
				res_status_q <= (kind_q == KIND_INSERT) && pool_full;
			end
			ST_WALK: begin
				cur_q <= link_rdata;
				if (key_rdata == key_q) begin
					res_found_q <= 1'b1;
				end
			end
			default: begin
			end
		endcase
		if (state_q == ST_DONE && rsp_free) begin
			rsp_q.found  <= res_found_q;
			rsp_q.status <= res_status_q;
		end
	end

	`CHS_ASSERT_ALWAYS(a_reset_clears, !arst_n |=> state_q == ST_CLEAR, "reset did not restart clearing")
	`CHS_ASSERT(a_pool_bound, nodes_taken_q <= NODES_C, "node count beyond pool size")
	`CHS_ASSERT(a_take_on_insert, nodes_taken_q != $past(nodes_taken_q) |-> $past(state_q == ST_BKT && kind_q == KIND_INSERT), "node taken outside an insert")
	`CHS_ASSERT(a_link_taken, link_we |-> CNT_W'(link_waddr) < nodes_taken_q, "link written on a free node")
	`CHS_ASSERT(a_walk_taken, state_q == ST_WALK |-> CNT_W'(cur_q) < nodes_taken_q, "chain walk reached a free node")

endmodule
`default_nettype wire

>>> tb/chained_hash_set_top_tb.sv
`default_nettype none
module chained_hash_set_top_tb
	import chs_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam int unsigned TAIL_CYCLES = 40;
	localparam int unsigned RANDOM_ITEMS = 630;

	logic     clk = 1'b0;
	logic     arst_n;
	logic     req_valid;
	logic     req_ready;
	chs_in_t  req;
	logic     rsp_valid;
	logic     rsp_ready;
	chs_out_t rsp;

	chained_hash_set_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	always #5 clk = ~clk;

	// shadow copy of the set
	bit               bkt_used[BUCKETS];
	int unsigned      bkt_head[BUCKETS];
	logic [KEY_W-1:0] node_val[NODES];
	int unsigned      node_next[NODES];
	bit               node_linked[NODES];
	int unsigned      nodes_used;

	chs_out_t         answers_due[$];
	logic [KEY_W-1:0] seen_keys[$];
	int unsigned      hot_bkt[16];
	int unsigned      errors;
	int unsigned      cycles;
	bit               quiet;

	function automatic chs_out_t set_apply(logic kind, logic [KEY_W-1:0] key);
		int unsigned b;
		int unsigned cur;
		int unsigned n;
		chs_out_t r;
		r = '0;
		b = key % BUCKETS;
		if (kind == KIND_INSERT) begin
			if (nodes_used >= NODES) begin
				r.status = 1'b1;
				return r;
			end
			node_val[nodes_used] = key;
			node_next[nodes_used] = 0;
			node_linked[nodes_used] = 1'b0;
			if (!bkt_used[b]) begin
				bkt_used[b] = 1'b1;
				bkt_head[b] = nodes_used;
			end else begin
				cur = bkt_head[b];
				for (n = 0; n < NODES && node_linked[cur]; n++)
					cur = node_next[cur];
				node_next[cur] = nodes_used;
				node_linked[cur] = 1'b1;
			end
			nodes_used++;
		end else if (bkt_used[b]) begin
			cur = bkt_head[b];
			for (n = 0; n < NODES; n++) begin
				if (node_val[cur] == key) begin
					r.found = 1'b1;
					break;
				end
				if (!node_linked[cur])
					break;
				cur = node_next[cur];
			end
		end
		return r;
	endfunction

	function automatic int unsigned gap_draw();
		return quiet ? 0 : $urandom_range(0, 19);
	endfunction

	function automatic logic [KEY_W-1:0] pick_key();
		logic [KEY_W-1:0] k;
		int unsigned sel;
		k = KEY_W'($urandom);
		sel = $urandom_range(0, 99);
		if (sel < 35) begin
			k = KEY_W'(k - (k % BUCKETS) + hot_bkt[$urandom_range(0, 15)]);
		end else if (sel < 65 && seen_keys.size() != 0) begin
			k = seen_keys[$urandom_range(0, seen_keys.size() - 1)];
		end else if (sel < 75) begin
			case ($urandom_range(0, 3))
				0: k = '0;
				1: k = '1;
				2: k = KEY_W'(BUCKETS - 1);
				default: k = KEY_W'(BUCKETS);
			endcase
		end
		return k;
	endfunction

	task automatic send_item(logic kind, logic [KEY_W-1:0] key);
		int unsigned gap;
		gap = gap_draw();
		if (gap != 0) begin
			@(negedge clk);
			req_valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		req_valid = 1'b1;
		req.kind = kind;
		req.key = key;
		do @(posedge clk); while (!req_ready);
		answers_due.push_back(set_apply(kind, key));
		if (kind == KIND_INSERT) begin
			seen_keys.push_back(key);
			if (seen_keys.size() > 64)
				void'(seen_keys.pop_front());
		end
	endtask

	task automatic wait_drained();
		@(negedge clk);
		req_valid = 1'b0;
		while (answers_due.size() != 0) @(posedge clk);
	endtask

	task automatic test_directed();
		send_item(KIND_SEARCH, 31'd5);          // empty bucket
		send_item(KIND_INSERT, 31'd0);
		send_item(KIND_SEARCH, 31'd0);
		send_item(KIND_SEARCH, 31'd1024);       // same bucket, absent
		send_item(KIND_INSERT, 31'd1024);
		send_item(KIND_INSERT, 31'd2048);
		send_item(KIND_SEARCH, 31'd2048);       // chain tail
		send_item(KIND_SEARCH, 31'd1024);       // chain middle
		send_item(KIND_SEARCH, 31'd3072);       // walks whole chain, misses
		send_item(KIND_INSERT, 31'd0);          // duplicate
		send_item(KIND_SEARCH, 31'd0);
		send_item(KIND_INSERT, 31'h7fffffff);
		send_item(KIND_SEARCH, 31'h7fffffff);
		send_item(KIND_SEARCH, 31'h7ffffbff);
		send_item(KIND_INSERT, 31'h55555555);
		send_item(KIND_INSERT, 31'h2aaaaaaa);
		send_item(KIND_SEARCH, 31'h55555555);
		send_item(KIND_SEARCH, 31'h2aaaaaaa);
		send_item(KIND_SEARCH, 31'h2aaaaaab);
	endtask

	task automatic test_random_traffic();
		int unsigned i;
		for (i = 0; i < 16; i++)
			hot_bkt[i] = $urandom_range(0, BUCKETS - 1);
		for (i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 40 == 0)
				quiet = ($urandom_range(0, 3) == 0);
			// let everything drain once mid-run, then resume
			if (i == RANDOM_ITEMS / 2)
				wait_drained();
			send_item($urandom_range(0, 1) ? KIND_SEARCH : KIND_INSERT, pick_key());
		end
		quiet = 1'b0;
	endtask

	// result checker
	always @(posedge clk) begin
		chs_out_t want;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t timeout after %0d cycles", $realtime, cycles);
			$display("*** FAILED ***");
			$finish;
		end
		if (arst_n && rsp_valid && rsp_ready) begin
			if (answers_due.size() == 0) begin
				$display("%0t unexpected transfer: found=%b status=%b",
					$realtime, rsp.found, rsp.status);
				errors++;
			end else begin
				want = answers_due.pop_front();
				if (rsp.found !== want.found) begin
					$display("%0t found mismatch: expected %b, got %b",
						$realtime, want.found, rsp.found);
					errors++;
				end
				if (rsp.status !== want.status) begin
					$display("%0t status mismatch: expected %b, got %b",
						$realtime, want.status, rsp.status);
					errors++;
				end
			end
		end
	end

	// result side back-pressure
	initial begin
		int unsigned stall;
		rsp_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = gap_draw();
			if (stall != 0) begin
				@(negedge clk);
				rsp_ready = 1'b0;
				repeat (stall - 1) @(negedge clk);
			end
			@(negedge clk);
			rsp_ready = 1'b1;
			do @(posedge clk); while (!(rsp_valid && rsp_ready));
		end
	end

	initial begin
		errors = 0;
		cycles = 0;
		quiet = 1'b0;
		nodes_used = 0;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_random_traffic();

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
`default_nettype wire

>>> chained_hash_set_top.f
+incdir+rtl
rtl/chs_pkg.sv
rtl/chs_ram.sv
rtl/chained_hash_set_top.sv
tb/chained_hash_set_top_tb.sv
